### design/cft_pkg.sv
// ----------------------------------------------------------------------------
// cft_pkg: shared types and constants of the csv field tokeniser
// Holds the byte constants, the field descriptor passed front to back and
// the whitespace test used when tracking trim bounds.
// ----------------------------------------------------------------------------
package cft_pkg;

  localparam logic [7:0] NewlineChar  = 8'd10;
  localparam logic [7:0] DelimReset   = 8'd44;
  localparam logic [7:0] QuoteReset   = 8'd34;

  // configuration register indexes
  localparam logic [1:0] CfgDelim = 2'd0;
  localparam logic [1:0] CfgQuote = 2'd1;
  localparam logic [1:0] CfgTrim  = 2'd2;

  // one finished field or bare row marker, front to back
  typedef struct packed {
    logic       bare;      // row-end marker with no field
    logic       row_end;
    logic       overflow;
    logic       last;      // final result of the input beat
    logic [6:0] lo;        // first buffer index to give out
    logic [6:0] hi;        // one past the last index
  } fld_desc_t;

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

### design/cft_front.sv
// ----------------------------------------------------------------------------
// cft_front: byte parser
// Runs the quote and delimiter state, writes field bytes into the buffer
// and posts a descriptor per finished field or row marker.
// ----------------------------------------------------------------------------
module cft_front #(
  parameter int FieldCap = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  input  logic [7:0]           char_in_i,
  input  logic [7:0]           delim_i,
  input  logic [7:0]           quote_i,
  input  logic                 trim_i,
  input  logic                 bank_i,    // buffer bank to write
  input  logic                 bank_free_i,
  output logic                 wr_en_o,
  output logic [5:0]           wr_addr_o,
  output logic [7:0]           wr_data_o,
  output logic                 push_o,
  output logic                 push2_o,   // second descriptor in same beat
  output cft_pkg::fld_desc_t   desc_o,
  output cft_pkg::fld_desc_t   desc2_o,
  output logic                 swap_o,    // field handed over, flip bank
  input  logic                 q_room2_i  // queue can take two entries
);

  logic [6:0] len_q, len_d;
  logic [5:0] first_q, first_d, lastns_q, lastns_d;
  logic       seen_q, seen_d, inq_q, inq_d, pend_q, pend_d;
  logic       started_q, started_d, quoted_q, quoted_d;
  logic       rowf_q, rowf_d, ovf_q, ovf_d;

  logic       accept;
  logic       store, emit, emit_re, rowmark, clr, endrow, flush;
  logic       outside;
  logic [7:0] c;
  cft_pkg::fld_desc_t fd;

  // need queue room and a free bank before each beat
  assign in_stall_o = !(q_room2_i && bank_free_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign c          = char_in_i;

  // classify the beat
  always_comb begin
    store = 1'b0; emit = 1'b0; emit_re = 1'b0; rowmark = 1'b0;
    clr = 1'b0; endrow = 1'b0; flush = 1'b0; outside = 1'b0;
    inq_d = inq_q; pend_d = pend_q; started_d = started_q; quoted_d = quoted_q;
    rowf_d = rowf_q;
    if (func_i) begin
      flush = 1'b1; endrow = 1'b1;
    end else if (pend_q) begin
      pend_d = 1'b0;
      if (c == quote_i) store = 1'b1;
      else begin
        inq_d = 1'b0; outside = 1'b1;
      end
    end else if (inq_q) begin
      if (c == quote_i) pend_d = 1'b1;
      else store = 1'b1;
    end else begin
      outside = 1'b1;
    end
    if (outside) begin
      if (c == quote_i) begin
        clr = started_q; inq_d = 1'b1; quoted_d = 1'b1; started_d = 1'b1;
      end else if (c == delim_i) begin
        emit = 1'b1; rowf_d = 1'b1; clr = 1'b1; started_d = 1'b0; quoted_d = 1'b0;
      end else if (c == cft_pkg::NewlineChar) begin
        endrow = 1'b1;
      end else if (!quoted_q) begin
        store = 1'b1; started_d = 1'b1;
      end
    end
    if (endrow) begin
      if (started_q) begin
        emit = 1'b1; emit_re = 1'b1;
      end else rowmark = rowf_q;
      clr = 1'b1; rowf_d = 1'b0; started_d = 1'b0; quoted_d = 1'b0;
    end
    if (flush) begin
      inq_d = 1'b0; pend_d = 1'b0; started_d = 1'b0; quoted_d = 1'b0;
      rowf_d = 1'b0;
    end
  end

  // buffer write and trim tracking
  always_comb begin
    len_d = len_q; first_d = first_q; lastns_d = lastns_q;
    seen_d = seen_q; ovf_d = ovf_q;
    wr_en_o = 1'b0;
    wr_addr_o = len_q[5:0];
    wr_data_o = c;
    if (clr) begin
      len_d = '0; first_d = '0; lastns_d = '0; seen_d = 1'b0; ovf_d = 1'b0;
    end else if (store) begin
      if (len_q < 7'(FieldCap)) begin
        wr_en_o = accept;
        if (!cft_pkg::is_space(c)) begin
          if (!seen_q) first_d = len_q[5:0];
          lastns_d = len_q[5:0];
          seen_d = 1'b1;
        end
        len_d = len_q + 7'd1;
      end else ovf_d = 1'b1;
    end
  end

  // field bounds after optional trim
  always_comb begin
    fd = '0;
    fd.lo = '0;
    fd.hi = len_q;
    if (trim_i && !quoted_q) begin
      if (seen_q) begin
        fd.lo = {1'b0, first_q};
        fd.hi = {1'b0, lastns_q} + 7'd1;
      end else fd.hi = '0;
    end
    fd.row_end  = emit_re;
    fd.overflow = ovf_q;
    fd.bare     = 1'b0;
    fd.last     = 1'b1;
  end

  always_comb begin
    desc_o  = fd;
    desc2_o = '0;
    push_o  = 1'b0;
    push2_o = 1'b0;
    swap_o  = 1'b0;
    if (accept) begin
      if (emit) begin
        push_o = 1'b1; swap_o = 1'b1;
      end else if (rowmark) begin
        push_o = 1'b1;
        desc_o = '0;
        desc_o.bare = 1'b1; desc_o.row_end = 1'b1; desc_o.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0; first_q <= '0; lastns_q <= '0; seen_q <= 1'b0;
      inq_q <= 1'b0; pend_q <= 1'b0; started_q <= 1'b0; quoted_q <= 1'b0;
      rowf_q <= 1'b0; ovf_q <= 1'b0;
    end else if (accept) begin
      len_q <= len_d; first_q <= first_d; lastns_q <= lastns_d; seen_q <= seen_d;
      inq_q <= inq_d; pend_q <= pend_d; started_q <= started_d;
      quoted_q <= quoted_d; rowf_q <= rowf_d; ovf_q <= ovf_d;
    end
  end

  logic unused;
  assign unused = bank_i;

endmodule

### design/cft_back.sv
// ----------------------------------------------------------------------------
// cft_back: field emitter
// Pops descriptors and reads the matching buffer bank byte by byte, one
// field at a time, presenting results through an output register.
// ----------------------------------------------------------------------------
module cft_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  cft_pkg::fld_desc_t q_desc_i,
  output logic               pop_o,
  output logic               rd_bank_o,
  output logic               done_o,      // bank finished with
  output logic [6:0]         rd_addr_o,
  input  logic [7:0]         rd_data_i,   // registered read data
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_char_o,
  output logic               char_valid_o,
  output logic               field_end_o,
  output logic               row_end_o,
  output logic               overflow_o,
  output logic               last_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StShow = 2'd2;

  logic [1:0]  st_q, st_d;
  logic [6:0]  idx_q, idx_d;
  logic        bank_q, bank_d;
  cft_pkg::fld_desc_t cur_q, cur_d;
  logic        ov_q, ov_d;
  logic [7:0]  och_q, och_d;
  logic        ocv_q, ocv_d, ofe_q, ofe_d, ore_q, ore_d, oov_q, oov_d, ol_q, ol_d;
  logic        fin;

  assign rd_addr_o = idx_q;
  assign rd_bank_o = bank_q;

  always_comb begin
    st_d = st_q; idx_d = idx_q; bank_d = bank_q; cur_d = cur_q; ov_d = ov_q;
    och_d = och_q; ocv_d = ocv_q; ofe_d = ofe_q; ore_d = ore_q; oov_d = oov_q;
    ol_d = ol_q;
    pop_o = 1'b0; done_o = 1'b0;
    fin = idx_q + 7'd1 >= cur_q.hi;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (st_q)
      StIdle: begin
        if (q_valid_i && (!ov_q || !out_stall_i)) begin
          pop_o = 1'b1;
          if (q_desc_i.bare || q_desc_i.lo >= q_desc_i.hi) begin
            // bare or empty result straight to output
            ov_d = 1'b1; och_d = '0; ocv_d = 1'b0;
            ofe_d = !q_desc_i.bare; ore_d = q_desc_i.row_end;
            oov_d = q_desc_i.overflow && !q_desc_i.bare; ol_d = 1'b1;
            if (!q_desc_i.bare) begin
              done_o = 1'b1; bank_d = !bank_q;
            end
          end else begin
            cur_d = q_desc_i; idx_d = q_desc_i.lo; st_d = StRead;
          end
        end
      end
      StRead: st_d = StShow;  // memory read latency
      StShow: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1; och_d = rd_data_i; ocv_d = 1'b1;
          ofe_d = fin; ore_d = fin && cur_q.row_end; oov_d = cur_q.overflow;
          ol_d = fin;
          if (fin) begin
            st_d = StIdle; done_o = 1'b1; bank_d = !bank_q;
          end else begin
            idx_d = idx_q + 7'd1; st_d = StRead;
          end
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; idx_q <= '0; bank_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; idx_q <= idx_d; bank_q <= bank_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; och_q <= och_d; ocv_q <= ocv_d; ofe_q <= ofe_d;
    ore_q <= ore_d; oov_q <= oov_d; ol_q <= ol_d;
  end

  assign out_valid_o  = ov_q;
  assign out_char_o   = och_q;
  assign char_valid_o = ocv_q;
  assign field_end_o  = ofe_q;
  assign row_end_o    = ore_q;
  assign overflow_o   = oov_q;
  assign last_o       = ol_q;

endmodule

### design/csv_field_tokenizer.sv
// field bytes: each emitted byte passes a buffer read then the output reg, one byte at a time
// parsing: one input beat per cycle while a buffer bank and queue room exist
// two buffer banks; input stalls while both banks hold fields not yet emitted
// a field end beat passes the descriptor queue; with the emitter idle a bare
// result then passes the output reg, a field byte the buffer read then the output reg
// reset: asynchronous active low, clears parser, queue and emitter control
// ----------------------------------------------------------------------------
// csv_field_tokenizer: top level of the csv field tokeniser
// Front parser, descriptor queue, two-bank field buffer and back emitter.
// ----------------------------------------------------------------------------
module csv_field_tokenizer #(
  parameter int FieldCap = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       func_i,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       char_valid_o,
  output logic       field_end_o,
  output logic       row_end_o,
  output logic       overflow_o,
  output logic       last_o
);

  logic [7:0] delim_q, quote_q;
  logic       trim_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= cft_pkg::DelimReset; quote_q <= cft_pkg::QuoteReset; trim_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cft_pkg::CfgDelim: delim_q <= cfg_data_i;
        cft_pkg::CfgQuote: quote_q <= cfg_data_i;
        cft_pkg::CfgTrim:  trim_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic wr_en, push, push2, swap, pop, rd_bank, done;
  logic [5:0] wr_addr;
  logic [6:0] rd_addr;
  logic [7:0] wr_data, rd_data_q;
  cft_pkg::fld_desc_t desc, desc2, qhead;
  logic wbank_q;
  logic [1:0] busy_q;   // banks holding fields not yet emitted
  logic [7:0] mem [2][64];

  // descriptor queue, four deep
  cft_pkg::fld_desc_t fifo_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + 2'(push);
      rp_q  <= rp_q + 2'(pop);
      cnt_q <= cnt_q + 3'(push) - 3'(pop);
    end
  end
  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= desc;
  end
  assign qhead = fifo_q[rp_q];

  // bank ownership: writer moves on at each handed-over field
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wbank_q <= 1'b0; busy_q <= '0;
    end else begin
      if (swap) wbank_q <= !wbank_q;
      busy_q <= busy_q + 2'(swap) - 2'(done);
    end
  end

  // two-bank field buffer
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wbank_q][wr_addr] <= wr_data;
    rd_data_q <= mem[rd_bank][rd_addr[5:0]];
  end

  cft_front #(.FieldCap(FieldCap)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i, .char_in_i,
    .delim_i(delim_q), .quote_i(quote_q), .trim_i(trim_q),
    .bank_i(wbank_q), .bank_free_i(busy_q < 2'd2),
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data),
    .push_o(push), .push2_o(push2), .desc_o(desc), .desc2_o(desc2),
    .swap_o(swap), .q_room2_i(cnt_q <= 3'd2)
  );

  cft_back u_back (
    .clk_i, .rst_ni, .q_valid_i(cnt_q != 3'd0), .q_desc_i(qhead), .pop_o(pop),
    .rd_bank_o(rd_bank), .done_o(done), .rd_addr_o(rd_addr), .rd_data_i(rd_data_q),
    .out_valid_o, .out_stall_i, .out_char_o, .char_valid_o, .field_end_o,
    .row_end_o, .overflow_o, .last_o
  );

  logic unused;
  assign unused = push2 ^ (|desc2) ^ rd_addr[6];

`ifndef NO_ASSERTIONS
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("descriptor queue overrun");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != 3'd0) else $error("pop from empty queue");
  a_bank_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q <= 2'd2) else $error("buffer banks overcommitted");
`endif

endmodule

### bench/tb_csv_field_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_csv_field_tokenizer: self-checking bench for the csv field tokeniser
// Feeds directed and random csv text through the input channel, predicts the
// field and row beats in a software parser and compares every output beat.
// ----------------------------------------------------------------------------
module tb_csv_field_tokenizer;

  typedef struct packed {
    logic       func;
    logic [7:0] ch;
  } text_beat_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       cv;
    logic       fe;
    logic       re;
    logic       ov;
    logic       lst;
  } tok_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [7:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       func_i = 1'b0;
  logic [7:0] char_in_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_char_o;
  logic       char_valid_o, field_end_o, row_end_o, overflow_o, last_o;

  csv_field_tokenizer u_dut (.*);

  // shadow parser state
  logic [7:0] sh_delim, sh_quote;
  logic       sh_trim;
  logic [7:0] fbuf [64];
  int         flen, first_ns, last_ns;
  bit         seen_ns, in_q, q_pend, f_started, f_quoted, row_fields, f_ovf;

  text_beat_t text_q[$];
  tok_beat_t  token_q[$];
  tok_beat_t  step_q[$];
  int         errors = 0;
  int         idle_pct = 27;
  int         hold_off = 0;
  bit         drv_pause = 1'b0;
  bit         in_fire = 1'b0;

  function automatic bit ws(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void clear_field();
    flen = 0; first_ns = 0; last_ns = 0; seen_ns = 0; f_ovf = 0;
  endfunction

  function automatic void clear_all();
    clear_field();
    in_q = 0; q_pend = 0; f_started = 0; f_quoted = 0; row_fields = 0;
  endfunction

  function automatic void push_tok(logic [7:0] c, bit cv, bit fe, bit re, bit ov);
    tok_beat_t t;
    t.ch = c; t.cv = cv; t.fe = fe; t.re = re; t.ov = ov; t.lst = 0;
    step_q.insert(step_q.size(), t);
  endfunction

  function automatic void add_beat(bit f, logic [7:0] c);
    text_beat_t b;
    b.func = f; b.ch = c;
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic void keep_byte(logic [7:0] c);
    if (flen < 64) begin
      fbuf[flen] = c;
      if (!ws(c)) begin
        if (!seen_ns) first_ns = flen;
        last_ns = flen;
        seen_ns = 1;
      end
      flen++;
    end else begin
      f_ovf = 1;
    end
  endfunction

  function automatic void give_field(bit re);
    int lo, hi;
    lo = 0; hi = flen;
    if (sh_trim && !f_quoted) begin
      if (seen_ns) begin
        lo = first_ns; hi = last_ns + 1;
      end else begin
        hi = 0;
      end
    end
    if (lo >= hi) push_tok(8'd0, 0, 1, re, f_ovf);
    else for (int i = lo; i < hi; i++) push_tok(fbuf[i], 1, i + 1 == hi,
                                               (i + 1 == hi) && re, f_ovf);
  endfunction

  function automatic void close_row();
    if (f_started) give_field(1);
    else if (row_fields) push_tok(8'd0, 0, 0, 1, 0);
    clear_field();
    row_fields = 0; f_started = 0; f_quoted = 0;
  endfunction

  function automatic void plain_byte(logic [7:0] c);
    if (c == sh_quote) begin
      if (f_started) clear_field();
      in_q = 1; f_quoted = 1; f_started = 1;
    end else if (c == sh_delim) begin
      give_field(0);
      row_fields = 1;
      clear_field();
      f_started = 0; f_quoted = 0;
    end else if (c == cft_pkg::NewlineChar) begin
      close_row();
    end else if (!f_quoted) begin
      keep_byte(c);
      f_started = 1;
    end
  endfunction

  // predicts the token beats that one text beat causes
  function automatic void tokenise(text_beat_t b);
    step_q.delete();
    if (b.func) begin
      close_row();
      clear_all();
    end else if (q_pend) begin
      q_pend = 0;
      if (b.ch == sh_quote) keep_byte(b.ch);
      else begin
        in_q = 0;
        plain_byte(b.ch);
      end
    end else if (in_q) begin
      if (b.ch == sh_quote) q_pend = 1;
      else keep_byte(b.ch);
    end else begin
      plain_byte(b.ch);
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].lst = 1;
    foreach (step_q[i]) token_q.insert(token_q.size(), step_q[i]);
  endfunction

  initial forever #2 clk_i = ~clk_i;

  // input handshake seen at the rising edge
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
  end

  // driver: one text beat per handshake from the pending queue
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) void'(text_q.pop_front());
      if (in_valid_i && !in_fire) begin
        // stalled beat holds its payload
      end else if (text_q.size() > 0 && !drv_pause &&
                   $urandom_range(99) >= idle_pct) begin
        in_valid_i <= 1'b1;
        func_i     <= text_q[0].func;
        char_in_i  <= text_q[0].ch;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      out_stall_i <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  // predictor on accepted text beats, checker on accepted token beats
  always @(posedge clk_i) begin
    tok_beat_t e;
    if (rst_ni && in_valid_i && !in_stall_o) tokenise('{func_i, char_in_i});
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (token_q.size() == 0) begin
        $error("unexpected token beat char %0h", out_char_o);
        errors++;
      end else begin
        e = token_q.pop_front();
        if (out_char_o !== e.ch) begin
          $error("out_char exp %0h got %0h", e.ch, out_char_o); errors++;
        end
        if (char_valid_o !== e.cv) begin
          $error("char_valid exp %0b got %0b", e.cv, char_valid_o); errors++;
        end
        if (field_end_o !== e.fe) begin
          $error("field_end exp %0b got %0b", e.fe, field_end_o); errors++;
        end
        if (row_end_o !== e.re) begin
          $error("row_end exp %0b got %0b", e.re, row_end_o); errors++;
        end
        if (overflow_o !== e.ov) begin
          $error("overflow exp %0b got %0b", e.ov, overflow_o); errors++;
        end
        if (last_o !== e.lst) begin
          $error("last exp %0b got %0b", e.lst, last_o); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic wait_drain();
    while (text_q.size() > 0 || in_valid_i || token_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == cft_pkg::CfgDelim) sh_delim = val;
    else if (idx == cft_pkg::CfgQuote) sh_quote = val;
    else sh_trim = val[0];
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_beat(1'b0, s[i]);
  endtask

  task automatic add_end();
    add_beat(1'b1, 8'($urandom_range(255)));
  endtask

  // one random row of well-formed fields with some noise
  task automatic add_row();
    int nf, nl;
    logic [7:0] c;
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      nl = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 6);
      if ($urandom_range(2) == 0) begin
        add_beat(1'b0, sh_quote);
        for (int k = 0; k < nl; k++) begin
          c = ($urandom_range(4) == 0) ? sh_quote : 8'($urandom_range(255));
          add_beat(1'b0, c);
          if (c == sh_quote) add_beat(1'b0, c);
        end
        add_beat(1'b0, sh_quote);
        if ($urandom_range(5) == 0) add_beat(1'b0, 8'd120);
      end else begin
        for (int k = 0; k < nl; k++) begin
          c = ($urandom_range(3) == 0) ? 8'd32 : 8'($urandom_range(255));
          if ($urandom_range(9) == 0) c = 8'($urandom_range(9, 13));
          add_beat(1'b0, c);
        end
      end
      if (f + 1 < nf) add_beat(1'b0, sh_delim);
    end
    if ($urandom_range(7) == 0) add_end();
    else add_beat(1'b0, cft_pkg::NewlineChar);
  endtask

  initial begin
    sh_delim = cft_pkg::DelimReset; sh_quote = cft_pkg::QuoteReset; sh_trim = 0;
    clear_all();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: plain, quoted, doubled quote, quote after content, empties
    add_text("ab,\"c\"\"d\",\"x\"junk,ef\"gh\"\n,,\n\n");
    add_text("\"open");
    add_end();
    add_end();
    add_beat(1'b0, 8'hFF);
    add_beat(1'b0, 8'h00);
    add_beat(1'b0, cft_pkg::NewlineChar);
    wait_drain();

    // trim on, odd delimiter and quote, overflowing field
    set_reg(cft_pkg::CfgTrim, 8'd1);
    set_reg(cft_pkg::CfgDelim, 8'hFF);
    set_reg(cft_pkg::CfgQuote, 8'h00);
    add_text("  a b \t");
    add_beat(1'b0, 8'hFF);
    add_text("   ");
    add_beat(1'b0, 8'hFF);
    add_beat(1'b0, 8'h00);
    add_text(" q ");
    add_beat(1'b0, 8'h00);
    add_beat(1'b0, cft_pkg::NewlineChar);
    for (int i = 0; i < 70; i++) add_beat(1'b0, 8'($urandom_range(33, 126)));
    add_end();
    wait_drain();

    // random phases over several settings; long stall then no idling
    for (int ph = 0; ph < 4; ph++) begin
      set_reg(cft_pkg::CfgDelim,
              ph == 3 ? 8'h00 : (ph == 2 ? 8'd59 : cft_pkg::DelimReset));
      set_reg(cft_pkg::CfgQuote,
              ph == 3 ? 8'hFF : (ph == 1 ? 8'd39 : cft_pkg::QuoteReset));
      set_reg(cft_pkg::CfgTrim, 8'(ph % 2));
      idle_pct = (ph == 2) ? 0 : 27;
      if (ph == 1) hold_off = 400;
      for (int r = 0; r < 2; r++) add_row();
      for (int r = 0; r < 16; r++) add_beat(1'b0, 8'($urandom_range(255)));
      add_end();
      if (ph == 0) begin
        while (text_q.size() > 20) @(posedge clk_i);
        drv_pause = 1'b1;
        while (in_valid_i || token_q.size() > 0) @(posedge clk_i);
        drv_pause = 1'b0;
      end
      wait_drain();
    end

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
